// ===== rtl/qpdh_pkg.sv =====
`default_nettype none
package qpdh_pkg;

    localparam int MAX_ITEMS_DEF    = 4096;
    localparam int ELEMENT_BITS_DEF = 8;

    localparam int SUM_W   = 21;
    localparam int SLOPE_W = 33;
    localparam int ICPT_W  = 64;
    localparam int BEST_W  = 63;
    localparam int COEF_A_W = 11;
    localparam int COEF_B_W = 25;
    localparam int COEF_C_W = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [63:0] BEST_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] BEST_MIN = 64'shC000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A = 2'd0,
        CFG_COEF_B = 2'd1,
        CFG_COEF_C = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
    } t_line;

    typedef struct packed {
        logic accept;
        logic sq;
        logic sq2;
        logic search;
        logic mul_lines;
        logic scmp;
        logic best;
        logic newl;
        logic top;
        logic popa;
        logic pmag;
        logic pstep;
        logic pdec;
        logic write;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic search_more;
        logic top_push;
        logic n_ge2;
        logic mul_last;
        logic useless;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/qpdh_ctrl.sv =====
`default_nettype none
module qpdh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qpdh_pkg::t_sts i_sts,
    output qpdh_pkg::t_cmd o_cmd
);
    import qpdh_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_SQ    = 16'h0002,
        ST_SQ2   = 16'h0004,
        ST_SRCH  = 16'h0008,
        ST_SMUL  = 16'h0010,
        ST_SCMP  = 16'h0020,
        ST_LMUL  = 16'h0040,
        ST_BEST  = 16'h0080,
        ST_NEWL  = 16'h0100,
        ST_TOP   = 16'h0200,
        ST_POP   = 16'h0400,
        ST_PMAG  = 16'h0800,
        ST_PMUL  = 16'h1000,
        ST_PCMP  = 16'h2000,
        ST_WRITE = 16'h4000,
        ST_DONE  = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_SQ2;
            end
            ST_SQ2: begin
                o_cmd.sq2 = 1'b1;
                n_state   = ST_SRCH;
            end
            ST_SRCH: begin
                o_cmd.search = 1'b1;
                n_state = i_sts.search_more ? ST_SMUL : ST_LMUL;
            end
            ST_SMUL: begin
                o_cmd.mul_lines = 1'b1;
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                o_cmd.scmp = 1'b1;
                n_state    = ST_SRCH;
            end
            ST_LMUL: begin
                o_cmd.mul_lines = 1'b1;
                n_state = ST_BEST;
            end
            ST_BEST: begin
                o_cmd.best = 1'b1;
                n_state    = ST_NEWL;
            end
            ST_NEWL: begin
                o_cmd.newl = 1'b1;
                n_state    = ST_TOP;
            end
            ST_TOP: begin
                o_cmd.top = 1'b1;
                n_state   = i_sts.top_push ? ST_POP : ST_DONE;
            end
            ST_POP: begin
                if (i_sts.n_ge2) begin
                    o_cmd.popa = 1'b1;
                    n_state    = ST_PMAG;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_PMAG: begin
                o_cmd.pmag = 1'b1;
                n_state    = ST_PMUL;
            end
            ST_PMUL: begin
                o_cmd.pstep = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = ST_PCMP;
                end
            end
            ST_PCMP: begin
                if (i_sts.useless) begin
                    o_cmd.pdec = 1'b1;
                    n_state    = ST_POP;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.load = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/qpdh_dp.sv =====
`default_nettype none
module qpdh_dp #(
    parameter int MAX_ITEMS    = qpdh_pkg::MAX_ITEMS_DEF,
    parameter int ELEMENT_BITS = qpdh_pkg::ELEMENT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qpdh_pkg::t_cmd                    i_cmd,
    output qpdh_pkg::t_sts                    o_sts,
    input  logic [ELEMENT_BITS-1:0]           i_element,
    input  logic                              i_first,
    input  logic                              i_cfg_valid,
    input  logic [qpdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qpdh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [qpdh_pkg::BEST_W-1:0]       o_best_value,
    output logic                              o_overflow
);
    import qpdh_pkg::*;

    localparam int LINE_CAP = MAX_ITEMS + 1;
    localparam int AW = $clog2(LINE_CAP);
    localparam int CW = $clog2(LINE_CAP + 1);

    function automatic logic [63:0] mag64(input logic signed [63:0] x,
                                          input logic signed [63:0] y);
        mag64 = (x >= y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [33:0] mag34(input logic signed [SLOPE_W-1:0] x,
                                          input logic signed [SLOPE_W-1:0] y);
        logic signed [33:0] xe;
        logic signed [33:0] ye;
        xe = 34'(x);
        ye = 34'(y);
        mag34 = (xe >= ye) ? 34'(xe - ye) : 34'(ye - xe);
    endfunction

    // configuration
    logic signed [COEF_A_W-1:0] r_coef_a;
    logic signed [COEF_B_W-1:0] r_coef_b;
    logic signed [COEF_C_W-1:0] r_coef_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= -11'sd1;
            r_coef_b <= '0;
            r_coef_c <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_A: r_coef_a <= i_cfg_data[COEF_A_W-1:0];
                CFG_COEF_B: r_coef_b <= i_cfg_data[COEF_B_W-1:0];
                CFG_COEF_C: r_coef_c <= i_cfg_data[COEF_C_W-1:0];
                default: ;
            endcase
        end
    end

    // line store
    t_line r_mem [LINE_CAP];
    t_line r_rda;
    t_line r_rdb;
    logic [AW-1:0] r_ra, r_rb, n_ra, n_rb;

    logic [SUM_W-1:0] r_sum;
    logic [CW-1:0]    r_count, r_n;
    logic             r_z0;
    logic [AW-1:0]    r_lo, r_hi;
    logic [AW-1:0]    mid;

    logic [2*SUM_W-1:0]    r_ss;
    logic signed [32:0]    r_as;
    logic signed [46:0]    r_bs;
    logic signed [63:0]    r_ass;
    logic signed [63:0]    r_pa, r_pb, r_ia, r_ib;
    logic signed [63:0]    r_best;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [63:0]    r_icpt;
    logic [63:0]           r_da, r_db;
    logic [33:0]           r_sa, r_sb;
    logic                  r_na, r_nb;
    logic [2:0]            r_step;
    logic [97:0]           r_acca, r_accb;
    logic                  r_ovf;
    logic                  r_oval;
    logic [BEST_W-1:0]     r_obest;
    logic                  r_oovf;

    t_line line_a, line_b;
    logic signed [SUM_W:0] s22;
    logic [CW-1:0] base_cnt;
    logic [SUM_W:0] sum_ext;
    logic signed [54:0] pa55, pb55;
    logic signed [53:0] ass54;
    logic signed [63:0] bs64, c64, raw, va, vb;
    logic signed [33:0] sl34;
    logic [31:0] mx;
    logic [16:0] my;
    logic [48:0] pp;
    logic [97:0] ppsh;
    logic cmp_lt, cmp_eq, cmp_gt_i;
    logic za, zb;
    logic useless;
    logic out_free;

    assign line_a = (r_ra == '0 && r_z0) ? t_line'('0) : r_rda;
    assign line_b = (r_rb == '0 && r_z0) ? t_line'('0) : r_rdb;
    assign s22    = $signed({1'b0, r_sum});
    assign base_cnt = i_first ? CW'(1) : r_count;
    assign sum_ext  = (i_first ? (SUM_W+1)'(0) : {1'b0, r_sum}) + (SUM_W+1)'(i_element);
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign pa55   = line_a.slope * s22;
    assign pb55   = line_b.slope * s22;
    assign ass54  = r_coef_a * $signed({1'b0, r_ss});
    assign bs64   = 64'(r_bs);
    assign c64    = 64'(r_coef_c);
    assign raw    = r_pa + r_ia + r_ass + bs64 + c64;
    assign va     = r_pa + r_ia;
    assign vb     = r_pb + r_ib;
    assign sl34   = -$signed({r_as, 1'b0});
    assign cmp_lt   = r_slope < line_a.slope;
    assign cmp_eq   = r_slope == line_a.slope;
    assign cmp_gt_i = r_icpt > line_a.icpt;

    // one 32x17 partial product per step
    assign mx   = r_step[1] ? (r_step[2] ? r_db[63:32] : r_da[63:32])
                            : (r_step[2] ? r_db[31:0]  : r_da[31:0]);
    assign my   = r_step[0] ? (r_step[2] ? r_sb[33:17] : r_sa[33:17])
                            : (r_step[2] ? r_sb[16:0]  : r_sa[16:0]);
    assign pp   = mx * my;
    assign ppsh = (98'(pp) << (r_step[1] ? 32 : 0)) << (r_step[0] ? 17 : 0);

    // sign-magnitude compare of the two cross products, zero counts as positive
    assign za = (r_acca == '0);
    assign zb = (r_accb == '0);
    always_comb begin
        logic sa_n;
        logic sb_n;
        sa_n = r_na && !za;
        sb_n = r_nb && !zb;
        if (sa_n != sb_n) begin
            useless = sa_n;
        end else if (sa_n) begin
            useless = r_acca > r_accb;
        end else begin
            useless = r_acca < r_accb;
        end
    end

    assign out_free          = !r_oval || i_out_ready;
    assign o_sts.useless     = useless;
    assign o_sts.search_more = r_lo < r_hi;
    assign o_sts.top_push    = !cmp_lt && !(cmp_eq && !cmp_gt_i);
    assign o_sts.n_ge2       = r_n >= CW'(2);
    assign o_sts.mul_last    = (r_step == 3'd7);
    assign o_sts.out_free    = out_free;

    always_comb begin
        n_ra = r_ra;
        n_rb = r_rb;
        if (i_cmd.search) begin
            if (r_lo < r_hi) begin
                n_ra = mid;
                n_rb = mid + AW'(1);
            end else begin
                n_ra = r_lo;
            end
        end else if (i_cmd.best) begin
            n_ra = AW'(r_n - CW'(1));
        end else if (i_cmd.popa) begin
            n_ra = AW'(r_n - CW'(2));
            n_rb = AW'(r_n - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && r_n < CW'(LINE_CAP)) begin
            r_mem[AW'(r_n)] <= '{slope: r_slope, icpt: r_icpt};
        end
        r_rda <= r_mem[n_ra];
        r_rdb <= r_mem[n_rb];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= CW'(1);
            r_z0    <= 1'b1;
            r_n     <= CW'(1);
            r_lo    <= '0;
            r_hi    <= '0;
            r_ra    <= '0;
            r_rb    <= '0;
            r_step  <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_ra <= n_ra;
            r_rb <= n_rb;
            if (i_cmd.accept) begin
                r_sum   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                r_count <= base_cnt;
                r_n     <= base_cnt;
                r_lo    <= '0;
                r_hi    <= AW'(base_cnt - CW'(1));
                r_ovf   <= 1'b0;
                if (i_first) begin
                    r_z0 <= 1'b1;
                end
            end
            if (i_cmd.scmp) begin
                if (va < vb) begin
                    r_lo <= mid + AW'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            if (i_cmd.top && cmp_eq && cmp_gt_i) begin
                r_n <= r_n - CW'(1);
            end
            if (i_cmd.pdec) begin
                r_n <= r_n - CW'(1);
            end
            if (i_cmd.pmag) begin
                r_step <= '0;
            end else if (i_cmd.pstep) begin
                r_step <= r_step + 3'd1;
            end
            if (i_cmd.write) begin
                if (r_n >= CW'(LINE_CAP)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_n + CW'(1);
                    if (r_n == '0) begin
                        r_z0 <= 1'b0;
                    end
                end
            end
            if (i_cmd.load && out_free) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_ss <= r_sum * r_sum;
            r_as <= r_coef_a * s22;
            r_bs <= r_coef_b * s22;
        end
        if (i_cmd.sq2) begin
            r_ass <= 64'(ass54);
        end
        if (i_cmd.mul_lines) begin
            r_pa <= 64'(pa55);
            r_ia <= line_a.icpt;
            r_pb <= 64'(pb55);
            r_ib <= line_b.icpt;
        end
        if (i_cmd.best) begin
            if (raw > BEST_MAX) begin
                r_best <= BEST_MAX;
            end else if (raw < BEST_MIN) begin
                r_best <= BEST_MIN;
            end else begin
                r_best <= raw;
            end
        end
        if (i_cmd.newl) begin
            r_icpt  <= r_best + r_ass - bs64;
            r_slope <= sl34[SLOPE_W-1:0];
        end
        if (i_cmd.pmag) begin
            r_da   <= mag64(line_a.icpt, r_icpt);
            r_na   <= line_a.icpt < r_icpt;
            r_db   <= mag64(line_a.icpt, line_b.icpt);
            r_nb   <= line_a.icpt < line_b.icpt;
            r_sa   <= mag34(line_b.slope, line_a.slope);
            r_sb   <= mag34(r_slope, line_a.slope);
            r_acca <= '0;
            r_accb <= '0;
        end else if (i_cmd.pstep) begin
            if (r_step[2]) begin
                r_accb <= r_accb + ppsh;
            end else begin
                r_acca <= r_acca + ppsh;
            end
        end
        if (i_cmd.load && out_free) begin
            r_obest <= r_best[BEST_W-1:0];
            r_oovf  <= r_ovf;
        end
    end

    assign o_out_valid  = r_oval;
    assign o_best_value = r_obest;
    assign o_overflow   = r_oovf;

endmodule
`default_nettype wire

// ===== rtl/quadratic_partition_dp_hull_top.sv =====
`default_nettype none
// Convex hull trick segmentation engine. Each input transfer adds an element to a
// saturating prefix sum s and returns best = max over stored lines of (m*s + k)
// + a*s*s + b*s + c, saturated to 63 bits, then pushes the line (-2*a*s,
// best + a*s*s - b*s) onto the upper envelope, popping lines that become useless
// by an exact cross-multiplied breakpoint test. Setting first clears the sum and
// the envelope. When the envelope already holds MAX_ITEMS+1 lines after popping,
// the line is dropped and overflow is set. Items are processed one at a time:
// each item runs a binary search over the line memory (one read pair, one
// multiply and one compare per step), then a pop phase whose line tests are
// dominated by the serial 32x17 multiplier that forms the two 98-bit cross
// products. The result sits in an output register, so the next item is taken
// while the last result waits. Configuration writes are accepted every cycle
// and must only happen while idle.
module quadratic_partition_dp_hull_top #(
    parameter int MAX_ITEMS    = qpdh_pkg::MAX_ITEMS_DEF,
    parameter int ELEMENT_BITS = qpdh_pkg::ELEMENT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ELEMENT_BITS-1:0]          i_element,
    input  logic                             i_first,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [qpdh_pkg::BEST_W-1:0]      o_best_value,
    output logic                             o_overflow,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qpdh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qpdh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import qpdh_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    qpdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qpdh_dp #(
        .MAX_ITEMS    (MAX_ITEMS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_element    (i_element),
        .i_first      (i_first),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_best_value (o_best_value),
        .o_overflow   (o_overflow)
    );

endmodule
`default_nettype wire

// ===== rtl/qpdh_chk.sv =====
`default_nettype none
module qpdh_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [qpdh_pkg::BEST_W-1:0] o_best_value,
    input logic                        o_overflow,
    input logic                        o_cfg_ready
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_best_value) && $stable(o_overflow))
        else $error("stalled result changed");

    // one item at a time: drop ready after a transfer
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready after transfer");

    // a result needs an accepted item first
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("register port stalled");

endmodule

bind quadratic_partition_dp_hull_top qpdh_chk u_qpdh_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_best_value (o_best_value),
    .o_overflow   (o_overflow),
    .o_cfg_ready  (o_cfg_ready)
);
`default_nettype wire
